@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers included by the pid controller top level
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PIDAW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pidaw assertion failed");
`define PIDAW_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pidaw forbidden condition seen");
`else
`define PIDAW_ASSERT(lbl, clk, rstn, prop)
`define PIDAW_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ design/pidaw_pkg.sv @@
// ----------------------------------------------------------------------------
// pidaw_pkg
// shared types, register indexes and saturation helpers of the pid controller
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GAIN_W = 32;
  localparam int ACT_W  = 48;
  localparam int IDEAL_W = 50;
  localparam int ACC_W  = 128;
  localparam int OP_W   = 64;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_UMAX  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_UMIN  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_TS    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_AWEN  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PMUL,
    ST_IMUL1,
    ST_IMUL2,
    ST_DMUL,
    ST_DDIV,
    ST_SUM
  } pidaw_state_t;

  // magnitude plus sign, truncated and saturated to the 48 bit action range
  function automatic logic [ACT_W-1:0] sat48(input logic [ACC_W-1:0] m, input logic neg);
    logic [ACT_W-1:0] lim;
    logic [ACT_W-1:0] v;
    lim = neg ? {1'b1, {(ACT_W-1){1'b0}}} : {1'b0, {(ACT_W-1){1'b1}}};
    v = m[ACT_W-1:0];
    if ((|m[ACC_W-1:ACT_W]) || (v > lim)) v = lim;
    return neg ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [GAIN_W-1:0] mag32(input logic [GAIN_W-1:0] x);
    return x[GAIN_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

@@ design/pidaw_mul.sv @@
// ----------------------------------------------------------------------------
// pidaw_mul
// 64 x 64 unsigned multiply built from four passes of one 32 x 32 multiplier
// ----------------------------------------------------------------------------
module pidaw_mul
  import pidaw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [OP_W-1:0]  op_a,
  input  logic [OP_W-1:0]  op_b,
  output logic             done,
  output logic [ACC_W-1:0] result
);

  logic [OP_W-1:0]  a_r, b_r;
  logic [OP_W-1:0]  prod_r;
  logic [1:0]       shp_r;
  logic [2:0]       cnt_r;
  logic             busy_r, done_r;
  logic [ACC_W-1:0] acc_r;
  logic [31:0]      limb_a, limb_b;
  logic [ACC_W-1:0] prod_ext;

  assign limb_a = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign limb_b = cnt_r[0] ? b_r[63:32] : b_r[31:0];

  // place the previous partial product at limb offset 0, 1 or 2
  always_comb begin
    case (shp_r)
      2'd0:    prod_ext = {64'd0, prod_r};
      2'd1:    prod_ext = {32'd0, prod_r, 32'd0};
      default: prod_ext = {prod_r, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        prod_r <= limb_a * limb_b;
        shp_r  <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      end
      if (cnt_r != 3'd0) acc_r <= acc_r + prod_ext;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

@@ design/pidaw_div.sv @@
// ----------------------------------------------------------------------------
// pidaw_div
// restoring divider, one quotient bit per cycle, 48 bit quotient
// ----------------------------------------------------------------------------
module pidaw_div
  import pidaw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      divisor,
  input  logic [31:0]      rem_init,
  input  logic [ACT_W-1:0] num_low,
  output logic             done,
  output logic [ACT_W-1:0] quotient
);

  logic [31:0]      dsr_r, rem_r;
  logic [ACT_W-1:0] num_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [32:0]      rem2, diff;
  logic             ge;

  assign rem2 = {rem_r, num_r[ACT_W-1]};
  assign ge   = rem2 >= {1'b0, dsr_r};
  assign diff = rem2 - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 6'(ACT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end

  // dividend bits shift out of num_r while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dsr_r <= divisor;
      rem_r <= rem_init;
      num_r <= num_low;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem2[31:0];
      num_r <= {num_r[ACT_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

@@ design/pid_controller_anti_windup.sv @@
// ----------------------------------------------------------------------------
// pid_controller_anti_windup
// pid step with saturating error sum and gated integral action
// ----------------------------------------------------------------------------
// a sample takes three passes of the shared multiplier when sample_time is zero, four when
//   the derivative saturates before the divide, and four plus the bit-serial divider otherwise
// a new input is taken only after the result of the last one has been registered for the
//   output
// reset: rst_n synchronous, clears state, registers to their reset values
module pid_controller_anti_windup
  import pidaw_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // process_value, set_point
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // control, error_now, p_action, i_action, d_action
  output logic [((SAMPLE_WIDTH+177+7)/8)*8-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [GAIN_W-1:0]   cfg_wdata
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int EW  = SW + 1;
  localparam int DLW = SW + 2;
  localparam int OTW = ((SW + 177 + 7) / 8) * 8;
  localparam int ODW = 32 + EW + 3 * ACT_W;

  `include "assert_macros.svh"

  logic [GAIN_W-1:0] kp_r, ki_r, kd_r, umax_r, umin_r, ts_r;
  logic              awen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      umax_r <= 32'h7FFF_FFFF;
      umin_r <= 32'h8000_0000;
      ts_r   <= 32'h0001_0000;
      awen_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KP:   kp_r   <= cfg_wdata;
        REG_KI:   ki_r   <= cfg_wdata;
        REG_KD:   kd_r   <= cfg_wdata;
        REG_UMAX: umax_r <= cfg_wdata;
        REG_UMIN: umin_r <= cfg_wdata;
        REG_TS:   ts_r   <= cfg_wdata;
        REG_AWEN: awen_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pidaw_state_t state_r, state_nxt;

  logic [EW-1:0]      e_r, prev_error_r;
  logic [DLW-1:0]     delta_r;
  logic [31:0]        esum_r;
  logic [IDEAL_W-1:0] ideal_r;
  logic [ACT_W-1:0]   p_r, i_r, d_r;
  logic               out_valid_r;
  logic [OTW-1:0]     out_data_r;

  logic [SW-1:0]      pv, sp;
  logic [EW-1:0]      e_in, e_mag;
  logic [DLW-1:0]     delta_mag;
  logic [33:0]        s34;
  logic [31:0]        s_sat;
  logic               mul_start, div_start, mul_done, div_done;
  logic [OP_W-1:0]    mul_a, mul_b;
  logic [ACC_W-1:0]   mul_res;
  logic [ACT_W-1:0]   div_q;
  logic               d_ovf, aw_block, out_free;
  logic [IDEAL_W-1:0] u_sum, umax_x, umin_x;
  logic [31:0]        ctl;

  assign pv   = in_tdata[SW-1:0];
  assign sp   = in_tdata[2*SW-1:SW];
  assign e_in = {sp[SW-1], sp} - {pv[SW-1], pv};

  assign e_mag     = e_r[EW-1] ? (~e_r + 1'b1) : e_r;
  assign delta_mag = delta_r[DLW-1] ? (~delta_r + 1'b1) : delta_r;

  assign s34   = {{2{esum_r[31]}}, esum_r} + {{(34-EW){e_r[EW-1]}}, e_r};
  assign s_sat = (s34[33:31] == 3'b000 || s34[33:31] == 3'b111) ? s34[31:0]
               : (s34[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // quotient would reach 2^48 when the dividend's upper bits reach the period
  assign d_ovf = (|mul_res[ACC_W-1:64]) || (mul_res[63:32] >= ts_r);

  assign umax_x   = {{(IDEAL_W-32){umax_r[31]}}, umax_r};
  assign umin_x   = {{(IDEAL_W-32){umin_r[31]}}, umin_r};
  assign aw_block = awen_r && !($signed(ideal_r) < $signed(umax_x));

  assign u_sum = {{2{p_r[ACT_W-1]}}, p_r} + {{2{i_r[ACT_W-1]}}, i_r}
               + {{2{d_r[ACT_W-1]}}, d_r};

  always_comb begin
    if ($signed(u_sum) < $signed(umin_x))      ctl = umin_r;
    else if ($signed(u_sum) > $signed(umax_x)) ctl = umax_r;
    else                                       ctl = u_sum[31:0];
  end

  assign out_free = !out_valid_r || out_tready;

  pidaw_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  pidaw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (ts_r),
    .rem_init (mul_res[63:32]),
    .num_low  ({mul_res[31:0], 16'd0}),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        mul_start = 1'b1;
        mul_a     = OP_W'(mag32(kp_r));
        mul_b     = OP_W'(e_mag);
        state_nxt = ST_PMUL;
      end
      ST_PMUL: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = OP_W'(mag32(ki_r));
          mul_b     = OP_W'(mag32(esum_r));
          state_nxt = ST_IMUL1;
        end
      end
      ST_IMUL1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_res[OP_W-1:0];
          mul_b     = OP_W'(ts_r);
          state_nxt = ST_IMUL2;
        end
      end
      ST_IMUL2: begin
        if (mul_done) begin
          if (ts_r != '0) begin
            mul_start = 1'b1;
            mul_a     = OP_W'(mag32(kd_r));
            mul_b     = OP_W'(delta_mag);
            state_nxt = ST_DMUL;
          end else begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_DMUL: begin
        if (mul_done) begin
          if (d_ovf) begin
            state_nxt = ST_SUM;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DDIV;
          end
        end
      end
      ST_DDIV: begin
        if (div_done) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      esum_r       <= '0;
      ideal_r      <= '0;
    end else begin
      if (state_r == ST_PREP) esum_r <= s_sat;
      if (state_r == ST_SUM && out_free) begin
        ideal_r      <= u_sum;
        prev_error_r <= e_r;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) e_r <= e_in;
    if (state_r == ST_PREP)
      delta_r <= {e_r[EW-1], e_r} - {prev_error_r[EW-1], prev_error_r};
    if (state_r == ST_PMUL && mul_done)
      p_r <= sat48(mul_res, kp_r[31] ^ e_r[EW-1]);
    if (state_r == ST_IMUL2 && mul_done) begin
      i_r <= aw_block ? '0 : sat48({16'd0, mul_res[ACC_W-1:16]}, ki_r[31] ^ esum_r[31]);
      d_r <= '0;
    end
    if (state_r == ST_DMUL && mul_done && d_ovf)
      d_r <= sat48({ACC_W{1'b1}}, kd_r[31] ^ delta_r[DLW-1]);
    if (state_r == ST_DDIV && div_done)
      d_r <= sat48({{(ACC_W-ACT_W){1'b0}}, div_q}, kd_r[31] ^ delta_r[DLW-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_SUM && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM && out_free)
      out_data_r <= {{(OTW-ODW){1'b0}}, d_r, i_r, p_r, e_r, ctl};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PIDAW_ASSERT(a_ctl_in_limits, clk, rst_n,
    (out_valid_r && $signed(umin_r) <= $signed(umax_r)) |->
      ($signed(out_data_r[31:0]) <= $signed(umax_r) &&
       $signed(out_data_r[31:0]) >= $signed(umin_r)))
  `PIDAW_ASSERT(a_mul_done_state, clk, rst_n,
    mul_done |-> (state_r == ST_PMUL || state_r == ST_IMUL1 ||
                  state_r == ST_IMUL2 || state_r == ST_DMUL))
  `PIDAW_ASSERT(a_div_done_state, clk, rst_n, div_done |-> state_r == ST_DDIV)
  `PIDAW_ASSERT(a_result_from_sum, clk, rst_n,
    $rose(out_valid_r) |-> $past(state_r == ST_SUM))

endmodule

@@ bench/tb_pid_controller_anti_windup.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_controller_anti_windup
// drives process value and set point samples into the pid step under several register settings,
// predicts every result in the bench and compares it field by field
// ----------------------------------------------------------------------------
module tb_pid_controller_anti_windup;
  import pidaw_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int EW = SW + 1;
  localparam int IN_W = ((2*SW+7)/8)*8;
  localparam int OUT_W = ((SW+177+7)/8)*8;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0] d_act;
    logic [ACT_W-1:0] i_act;
    logic [ACT_W-1:0] p_act;
    logic [EW-1:0] err;
    logic [31:0] ctl;
  } pid_result_t;

  // predictor of one pid step, with its own copy of registers and state
  class pid_scoreboard;
    logic signed [31:0] gain_p, gain_i, gain_d, lim_hi, lim_lo;
    logic [31:0] period;
    bit aw_on;
    logic signed [EW-1:0] last_err;
    logic signed [31:0] err_acc;
    logic signed [IDEAL_W-1:0] unclamped;
    pid_result_t pending[$];
    int mismatches;

    function new();
      gain_p = 0; gain_i = 0; gain_d = 0;
      lim_hi = 32'h7fffffff; lim_lo = 32'h80000000;
      period = 32'h10000; aw_on = 0;
      last_err = 0; err_acc = 0; unclamped = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [31:0] v);
      case (idx)
        REG_KP: gain_p = v;
        REG_KI: gain_i = v;
        REG_KD: gain_d = v;
        REG_UMAX: lim_hi = v;
        REG_UMIN: lim_lo = v;
        REG_TS: period = v;
        REG_AWEN: aw_on = v[0];
        default: ;
      endcase
    endfunction

    // truncated magnitude saturated to the 48 bit action range
    function logic signed [ACT_W-1:0] clip(logic [255:0] m, bit neg);
      logic [255:0] lim;
      lim = neg ? (256'd1 << 47) : ((256'd1 << 47) - 1);
      if (m > lim) m = lim;
      return neg ? -$signed(m[ACT_W-1:0]) : $signed(m[ACT_W-1:0]);
    endfunction

    function logic [255:0] absv(logic signed [63:0] x);
      return x < 0 ? 256'(-x) : 256'(x);
    endfunction

    function void note_sample(logic signed [SW-1:0] pv, logic signed [SW-1:0] sp);
      logic signed [63:0] e, dlt, s, p, ia, d, u, c;
      logic [255:0] m;
      pid_result_t r;
      e = 64'(sp) - 64'(pv);
      dlt = e - 64'(last_err);
      s = 64'(err_acc) + e;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      err_acc = s[31:0];
      p = clip(absv(64'(gain_p)) * absv(e), (gain_p < 0) != (e < 0));
      m = (absv(64'(gain_i)) * absv(s) * 256'(period)) >> 16;
      ia = clip(m, (gain_i < 0) != (s < 0));
      if (aw_on && !(64'(unclamped) < 64'(lim_hi))) ia = 0;
      if (period != 0) begin
        m = ((absv(64'(gain_d)) * absv(dlt)) << 16) / 256'(period);
        d = clip(m, (gain_d < 0) != (dlt < 0));
      end else begin
        d = 0;
      end
      u = p + ia + d;
      unclamped = u[IDEAL_W-1:0];
      last_err = e[EW-1:0];
      if (u < 64'(lim_lo)) c = 64'(lim_lo);
      else if (u > 64'(lim_hi)) c = 64'(lim_hi);
      else c = u;
      r.ctl = c[31:0]; r.err = e[EW-1:0];
      r.p_act = p[ACT_W-1:0]; r.i_act = ia[ACT_W-1:0]; r.d_act = d[ACT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(pid_result_t got);
      pid_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.ctl !== exp_r.ctl || got.err !== exp_r.err || got.p_act !== exp_r.p_act
          || got.i_act !== exp_r.i_act || got.d_act !== exp_r.d_act) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: ctl %h/%h err %h/%h p %h/%h i %h/%h d %h/%h",
                   exp_r.ctl, got.ctl, exp_r.err, got.err, exp_r.p_act, got.p_act,
                   exp_r.i_act, got.i_act, exp_r.d_act, got.d_act);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_we;
  logic [IN_W-1:0] in_tdata;
  logic [OUT_W-1:0] out_tdata;
  logic [CFG_AW-1:0] cfg_addr;
  logic [GAIN_W-1:0] cfg_wdata;

  pid_scoreboard sb;
  int idle_cycles;
  bit quiet;

  pid_controller_anti_windup dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // results side: random stalls, check at the rising edge
  initial begin
    int wait_n;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      wait_n = quiet ? 0 : $urandom_range(0, 19);
      out_tready = 0;
      repeat (wait_n) @(negedge clk);
      out_tready = 1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata[$bits(pid_result_t)-1:0]);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("pid_controller_anti_windup regression: fail");
      $finish;
    end
  end

  task automatic send_sample(logic [SW-1:0] pv, logic [SW-1:0] sp);
    int wait_n;
    wait_n = quiet ? 0 : $urandom_range(0, 19);
    repeat (wait_n) @(negedge clk);
    in_tdata = {sp, pv};
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(pv, sp);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] v);
    cfg_we = 1; cfg_addr = idx; cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
    endcase
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return SW'($urandom);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  initial begin
    logic [SW-1:0] aim;
    sb = new();
    in_tvalid = 0; in_tdata = 0; cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    idle_cycles = 0; quiet = 0;
    rst_n = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    // reset gains: everything zero
    send_sample(16'h7fff, 16'h8000);
    drain();
    write_reg(REG_KP, 32'h7fffffff);
    write_reg(REG_KI, 32'h80000000);
    write_reg(REG_KD, 32'h7fffffff);
    write_reg(REG_TS, 32'h1);
    write_reg(REG_UNUSED, 32'hdeadbeef); // unused index is ignored
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h0, 16'h0);
    send_sample(16'h8000, 16'h7fff);
    drain();
    // zero period, crossed limits, anti-windup gating
    write_reg(REG_TS, 32'h0);
    write_reg(REG_UMAX, 32'hffff0000);
    write_reg(REG_UMIN, 32'h00010000);
    write_reg(REG_AWEN, 32'h1);
    write_reg(REG_KI, 32'h00010000);
    write_reg(REG_KP, 32'h00010000);
    send_sample(16'h0, 16'h0005);
    send_sample(16'h0, 16'hfffb);
    send_sample(16'h0, 16'h0000);
    drain();
    write_reg(REG_TS, 32'hffffffff);
    write_reg(REG_UMAX, 32'h00100000);
    write_reg(REG_UMIN, 32'hfff00000);
    for (int i = 0; i < 8; i++) send_sample(16'h0, 16'h7fff);
    for (int i = 0; i < 4; i++) send_sample(16'h0, 16'h8000);
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      write_reg(REG_KP, pick_gain());
      write_reg(REG_KI, pick_gain());
      write_reg(REG_KD, pick_gain());
      write_reg(REG_UMAX, $urandom_range(0, 3) == 0 ? 32'h7fffffff : $urandom);
      write_reg(REG_UMIN, $urandom_range(0, 3) == 0 ? 32'h80000000 : $urandom);
      case ($urandom_range(0, 4))
        0: write_reg(REG_TS, 0);
        1: write_reg(REG_TS, 32'hffffffff);
        2: write_reg(REG_TS, $urandom);
        default: write_reg(REG_TS, $urandom_range(1, 32'h40000));
      endcase
      write_reg(REG_AWEN, $urandom_range(0, 1));
      quiet = (ph % 5 == 4);
      aim = pick_sample();
      for (int i = 0; i < 50; i++) begin
        // mostly a tracking loop around one set point, some wild samples
        if ($urandom_range(0, 3) == 0) send_sample(pick_sample(), pick_sample());
        else send_sample(aim + 16'($signed($urandom_range(0, 64)) - 32), aim);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("pid_controller_anti_windup regression: pass");
    else
      $display("pid_controller_anti_windup regression: fail");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/pidaw_pkg.sv
design/pidaw_mul.sv
design/pidaw_div.sv
design/pid_controller_anti_windup.sv
bench/tb_pid_controller_anti_windup.sv
